>>> rtl/stpseq_pkg.sv
// Shared types and constants of the full-step stepper sequencer.
// Used by stpseq_next and stepper_full_step_sequencer_unit; depends on nothing.
package stpseq_pkg;

   localparam int unsigned SPR_W   = 16;
   localparam int unsigned DELAY_W = 32;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   // Action codes of a request.
   localparam logic [2:0] ACT_TICK      = 3'd0;
   localparam logic [2:0] ACT_MOVE_REL  = 3'd1;
   localparam logic [2:0] ACT_MOVE_HOME = 3'd2;
   localparam logic [2:0] ACT_MOVE_ZERO = 3'd3;
   localparam logic [2:0] ACT_SET_HOME  = 3'd4;
   localparam logic [2:0] ACT_SET_ZERO  = 3'd5;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_ROTATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_DELAY_TICKS   = 2'd1;

   localparam logic [SPR_W-1:0]   SPR_RESET   = 16'd200;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd180000;

   localparam logic [3:0] COILS_OFF = 4'b0000;

   typedef struct packed {
      logic [2:0]               action;
      logic signed [POS_W-1:0]  steps;
   } req_type;

   typedef struct packed {
      logic [3:0]               coils;
      logic signed [POS_W-1:0]  position;
      logic [SPR_W-1:0]         rotation_step;
      logic                     moving;
      logic                     stepped;
      logic                     rejected;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]   position_count;
      logic [SPR_W-1:0]   rotation_count;
      logic [POS_W-1:0]   steps_remaining;
      logic               direction_forward;
      logic [DELAY_W-1:0] delay_counter;
      logic [3:0]         coil_pattern;
   } state_type;

   // Full-step coil pattern for the rotation counter modulo four.
   function automatic logic [3:0] coil_lookup(input logic [1:0] phase);
      logic [3:0] pattern;
      case (phase)
         2'd0:    pattern = 4'b1010;
         2'd1:    pattern = 4'b0110;
         2'd2:    pattern = 4'b0101;
         default: pattern = 4'b1001;
      endcase
      return pattern;
   endfunction

endpackage

>>> rtl/stpseq_next.sv
// Next-state and result logic of the sequencer for one request.
// Depends on stpseq_pkg; purely combinational.
module stpseq_next (
   input  stpseq_pkg::state_type              state,
   input  stpseq_pkg::req_type                req,
   input  logic [stpseq_pkg::SPR_W-1:0]       steps_per_rotation,
   input  logic [stpseq_pkg::DELAY_W-1:0]     step_delay_ticks,
   output stpseq_pkg::state_type              state_next,
   output stpseq_pkg::rsp_type                rsp
);
   import stpseq_pkg::*;

   logic               busy;
   logic [SPR_W-1:0]   spr_eff;
   logic [SPR_W:0]     rot_inc;
   logic [SPR_W-1:0]   rot_stepped;
   logic [DELAY_W-1:0] delay_inc;
   logic [POS_W-1:0]   move_count;
   logic               move_start;
   logic               step_now;
   logic               rejected;

   assign busy    = state.steps_remaining != '0;
   assign spr_eff = (steps_per_rotation == '0) ? SPR_W'(1) : steps_per_rotation;
   assign rot_inc = {1'b0, state.rotation_count} + (SPR_W+1)'(1);
   assign delay_inc = state.delay_counter + DELAY_W'(1);

   // Rotation counter after one step in the current direction.
   always_comb begin
      if (state.direction_forward) begin
         rot_stepped = (rot_inc >= {1'b0, spr_eff}) ? '0 : rot_inc[SPR_W-1:0];
      end else if (state.rotation_count == '0) begin
         rot_stepped = spr_eff - SPR_W'(1);
      end else begin
         rot_stepped = state.rotation_count - SPR_W'(1);
      end
   end

   always_comb begin
      move_count = '0;
      move_start = 1'b0;
      step_now   = 1'b0;
      rejected   = 1'b0;
      state_next = state;
      case (req.action) inside
         ACT_TICK: begin
            if (busy) begin
               state_next.delay_counter = delay_inc;
               if (delay_inc >= step_delay_ticks) begin
                  state_next.delay_counter = '0;
                  step_now = 1'b1;
               end
            end
         end
         [ACT_MOVE_REL:ACT_SET_ZERO]: begin
            if (busy) begin
               rejected = 1'b1;
            end else begin
               case (req.action)
                  ACT_MOVE_REL: begin
                     move_count = req.steps;
                     move_start = 1'b1;
                  end
                  ACT_MOVE_HOME: begin
                     move_count = '0 - state.position_count;
                     move_start = 1'b1;
                  end
                  ACT_MOVE_ZERO: begin
                     // Moves only when off the zero of the rotation.
                     if (state.rotation_count != '0) begin
                        move_start = 1'b1;
                        if (state.rotation_count >= spr_eff) begin
                           move_count = POS_W'(1);
                        end else begin
                           move_count = POS_W'(spr_eff - state.rotation_count);
                        end
                     end
                  end
                  ACT_SET_HOME: state_next.position_count = '0;
                  default:      state_next.rotation_count = '0;
               endcase
            end
         end
         default: ;
      endcase

      if (move_start && move_count != '0) begin
         state_next.direction_forward = !move_count[POS_W-1];
         state_next.steps_remaining   = move_count[POS_W-1] ? ('0 - move_count) : move_count;
         state_next.delay_counter     = '0;
      end

      if (step_now) begin
         state_next.position_count  = state.direction_forward
                                      ? state.position_count + POS_W'(1)
                                      : state.position_count - POS_W'(1);
         state_next.rotation_count  = rot_stepped;
         state_next.steps_remaining = state.steps_remaining - POS_W'(1);
         state_next.coil_pattern    = coil_lookup(rot_stepped[1:0]);
      end
   end

   always_comb begin
      rsp.coils         = state_next.coil_pattern;
      rsp.position      = state_next.position_count;
      rsp.rotation_step = state_next.rotation_count;
      rsp.moving        = state_next.steps_remaining != '0;
      rsp.stepped       = step_now;
      rsp.rejected      = rejected;
   end

endmodule

>>> rtl/stepper_full_step_sequencer_unit.sv
// Top level of the full-step stepper sequencer: state, configuration and handshakes.
// Depends on stpseq_pkg and stpseq_next.
//
// Usage. Each request on req_ carries an action and a signed step count. A tick
// request counts the inter-step delay of a running move; the other actions start
// a relative move, a move home, a move to rotation zero, or clear the position or
// the rotation counter. Every accepted request yields exactly one result on rsp_,
// carrying the coil drive, the position, the step within the rotation and the
// moving, stepped and rejected flags.
// The result is registered and presented in the cycle after its request is accepted.
// Throughput is one request per cycle while no result waits under rsp_stall, which
// a tick stream needs; the figure is set by the single state update of each request.
// The result register lets a new request in whenever it is empty or being taken
// in the same cycle; req_stall is raised only while a result waits under rsp_stall.
// Reset (synchronous, active high) clears the motor state, switches all coils off,
// empties the result register and restores 200 steps per rotation and a delay of
// 180000 ticks. csr_ is always ready; writes should be made while the block idles.
module stepper_full_step_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  stpseq_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output stpseq_pkg::rsp_type                 rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stpseq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [stpseq_pkg::CSR_DATA_W-1:0]   csr_data
);
   import stpseq_pkg::*;

   logic [SPR_W-1:0]   spr_ff,   spr_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   state_type          state_calc;
   rsp_type            rsp_calc;
   logic               req_fire;
   logic               rsp_fire;

   // Configuration port: a write lands on the next edge; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      spr_in   = spr_ff;
      delay_in = delay_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STEPS_PER_ROTATION: spr_in   = csr_data[SPR_W-1:0];
            CSR_STEP_DELAY_TICKS:   delay_in = csr_data[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole state update for one request is worked out in a single pass.
   stpseq_next u_next (
      .state              (state_ff),
      .req                (req_data),
      .steps_per_rotation (spr_ff),
      .step_delay_ticks   (delay_ff),
      .state_next         (state_calc),
      .rsp                (rsp_calc)
   );

   // A request may enter whenever the result register will be free at this edge.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;

   always_comb begin
      state_in     = req_fire ? state_calc : state_ff;
      rsp_in       = req_fire ? rsp_calc : rsp_ff;
      rsp_valid_in = req_fire ? 1'b1 : (rsp_fire ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff       <= SPR_RESET;
         delay_ff     <= DELAY_RESET;
         state_ff     <= '{position_count:    '0,
                           rotation_count:    '0,
                           steps_remaining:   '0,
                           direction_forward: 1'b0,
                           delay_counter:     '0,
                           coil_pattern:      COILS_OFF};
         rsp_valid_ff <= 1'b0;
      end else begin
         spr_ff       <= spr_in;
         delay_ff     <= delay_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result payload needs no reset: it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The moving flag of a pending result always agrees with the state its request produced.
   a_moving_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.moving == (state_ff.steps_remaining != '0)))
      else $error("moving flag disagrees with steps remaining");

   // A step and a rejection cannot come from the same request.
   a_step_or_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.stepped && rsp_ff.rejected))
      else $error("result both stepped and rejected");

   // After a step the coils are always driven.
   a_step_drives_coils: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.stepped) |-> (rsp_ff.coils != COILS_OFF))
      else $error("step left the coils off");

   // A tick while idle leaves the position and the rotation counter alone.
   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.action == ACT_TICK && state_ff.steps_remaining == '0)
      |=> ($stable(state_ff.position_count) && $stable(state_ff.rotation_count)))
      else $error("idle tick moved the motor");

endmodule
